FILE: rtl/slfd_pkg.sv
// Shared types and constants for the sync/length frame deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package slfd_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] SYNC_VALUE_RST = 8'd22;
	localparam logic [7:0] DATA_CODE_RST  = 8'd2;

	// configuration register indexes
	localparam logic REG_SYNC_VALUE = 1'b0;
	localparam logic REG_DATA_CODE  = 1'b1;

	// one result on its way from the front end to the output stage
	typedef struct packed {
		logic       frame_end;
		logic [7:0] data;       // payload byte, or check byte at a data frame's end
		logic [7:0] index;
		logic [7:0] address;
		logic [7:0] control;
		logic [7:0] number;
		logic [7:0] length;
		logic       is_data;
	} entry_t;

endpackage

`default_nettype wire

FILE: rtl/slfd_front.sv
// Front end: configuration registers and the frame field tracker.
// Pushes one entry per result into the queue. Depends on slfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slfd_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire               cfg_index,
	input  wire [7:0]         cfg_data,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire [7:0]         rx_byte,
	input  wire               q_full,
	output logic              push,
	output slfd_pkg::entry_t  push_entry
);
	import slfd_pkg::*;

	localparam logic [2:0] POS_HUNT    = 3'd0;
	localparam logic [2:0] POS_ADDR    = 3'd1;
	localparam logic [2:0] POS_CTRL    = 3'd2;
	localparam logic [2:0] POS_NUM     = 3'd3;
	localparam logic [2:0] POS_LEN     = 3'd4;
	localparam logic [2:0] POS_PAYLOAD = 3'd5;
	localparam logic [2:0] POS_CHECK   = 3'd6;

	logic [7:0] sync_value_q;
	logic [7:0] data_code_q;
	logic [2:0] pos_q;
	logic       data_flag_q;
	logic [7:0] address_q;
	logic [7:0] control_q;
	logic [7:0] number_q;
	logic [7:0] length_q;
	logic [7:0] count_q;

	logic       accept;
	logic [7:0] count_inc;

	assign in_stall  = q_full;
	assign accept    = in_valid && !in_stall;
	assign count_inc = count_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_value_q <= SYNC_VALUE_RST;
			data_code_q  <= DATA_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_VALUE: sync_value_q <= cfg_data;
				REG_DATA_CODE:  data_code_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_HUNT;
			data_flag_q <= 1'b0;
			address_q   <= 8'd0;
			control_q   <= 8'd0;
			number_q    <= 8'd0;
			length_q    <= 8'd0;
			count_q     <= 8'd0;
		end else if (accept) begin
			case (pos_q)
				POS_ADDR: begin
					address_q <= rx_byte;
					pos_q     <= POS_CTRL;
				end
				POS_CTRL: begin
					control_q   <= rx_byte;
					data_flag_q <= (rx_byte == data_code_q);
					pos_q       <= POS_NUM;
				end
				POS_NUM: begin
					number_q <= rx_byte;
					pos_q    <= data_flag_q ? POS_LEN : POS_HUNT;
				end
				POS_LEN: begin
					length_q <= rx_byte;
					count_q  <= 8'd0;
					pos_q    <= (rx_byte == 8'd0) ? POS_CHECK : POS_PAYLOAD;
				end
				POS_PAYLOAD: begin
					if (count_inc == length_q) begin
						count_q <= 8'd0;
						pos_q   <= POS_CHECK;
					end else begin
						count_q <= count_inc;
					end
				end
				POS_CHECK: begin
					pos_q <= POS_HUNT;
				end
				default: begin
					// hunt; the unused code falls here too
					if (rx_byte == sync_value_q) begin
						pos_q       <= POS_ADDR;
						data_flag_q <= 1'b0;
						length_q    <= 8'd0;
						count_q     <= 8'd0;
					end else begin
						pos_q <= POS_HUNT;
					end
				end
			endcase
		end
	end

	// result classification; header fields come from the captured registers,
	// except the number byte which is captured in the same cycle
	always_comb begin
		push                 = 1'b0;
		push_entry.frame_end = 1'b0;
		push_entry.data      = 8'd0;
		push_entry.index     = 8'd0;
		push_entry.address   = address_q;
		push_entry.control   = control_q;
		push_entry.number    = number_q;
		push_entry.length    = length_q;
		push_entry.is_data   = data_flag_q;
		case (pos_q)
			POS_NUM: begin
				push                 = accept && !data_flag_q;
				push_entry.frame_end = 1'b1;
				push_entry.number    = rx_byte;
			end
			POS_PAYLOAD: begin
				push             = accept;
				push_entry.data  = rx_byte;
				push_entry.index = count_q;
			end
			POS_CHECK: begin
				push                 = accept;
				push_entry.frame_end = 1'b1;
				push_entry.data      = rx_byte;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/slfd_queue.sv
// Short FIFO of result entries between the front end and the output stage.
// Depends on slfd_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module slfd_queue #(
	parameter int unsigned DEPTH = slfd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  slfd_pkg::entry_t  push_entry,
	output logic              full,
	input  wire               pop,
	output logic              not_empty,
	output slfd_pkg::entry_t  pop_entry
);
	import slfd_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL) else $error("queue count out of range");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count did not advance on push");

endmodule

`default_nettype wire

FILE: rtl/slfd_back.sv
// Output stage: pops queue entries, formats the result fields, and holds
// them in the output register until taken. Depends on slfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slfd_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               q_not_empty,
	input  slfd_pkg::entry_t  q_entry,
	output logic              pop,
	output logic              out_valid,
	input  wire               out_stall,
	output logic              frame_end,
	output logic [7:0]        payload_byte,
	output logic [7:0]        payload_index,
	output logic [7:0]        dest_address,
	output logic [7:0]        control_code,
	output logic [7:0]        frame_number,
	output logic [7:0]        payload_length,
	output logic [7:0]        check_byte,
	output logic              is_data_frame
);
	import slfd_pkg::*;

	logic valid_q;
	logic load;

	assign load      = !valid_q || !out_stall;
	assign pop       = q_not_empty && load;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			frame_end      <= q_entry.frame_end;
			payload_byte   <= q_entry.frame_end ? 8'd0 : q_entry.data;
			payload_index  <= q_entry.index;
			dest_address   <= q_entry.address;
			control_code   <= q_entry.control;
			frame_number   <= q_entry.number;
			payload_length <= q_entry.is_data ? q_entry.length : 8'd0;
			check_byte     <= q_entry.frame_end ? q_entry.data : 8'd0;
			is_data_frame  <= q_entry.is_data;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sync_length_frame_deframer_top.sv
// Sync/length frame deframer: one received byte per cycle in while in_stall
// is low, payload and frame-end items out via the queue and the output register.
// Throughput: 1 item per cycle while out_stall is low; in_stall rises only when
// the result queue (QUEUE_DEPTH entries) is full because the output side is
// stalling. Reset: hunting for sync, header registers cleared, sync_value 22,
// data_control_code 2, queue and output register empty.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_frame_deframer_top #(
	parameter int unsigned QUEUE_DEPTH = slfd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire        cfg_index,
	input  wire [7:0]  cfg_data,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire [7:0]  rx_byte,
	output logic       out_valid,
	input  wire        out_stall,
	output logic       frame_end,
	output logic [7:0] payload_byte,
	output logic [7:0] payload_index,
	output logic [7:0] dest_address,
	output logic [7:0] control_code,
	output logic [7:0] frame_number,
	output logic [7:0] payload_length,
	output logic [7:0] check_byte,
	output logic       is_data_frame
);
	import slfd_pkg::*;

	logic   q_full;
	logic   q_not_empty;
	logic   push;
	logic   pop;
	entry_t push_entry;
	entry_t pop_entry;

	slfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	slfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.pop_entry  (pop_entry)
	);

	slfd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_not_empty    (q_not_empty),
		.q_entry        (pop_entry),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_end      (frame_end),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.dest_address   (dest_address),
		.control_code   (control_code),
		.frame_number   (frame_number),
		.payload_length (payload_length),
		.check_byte     (check_byte),
		.is_data_frame  (is_data_frame)
	);

endmodule

`default_nettype wire
